// File: sv/tepd_pkg.sv
// ============================================================================
// tepd_pkg: shared types and constants for the tilt estimate / PID duty block
// Holds the default parameter values, fixed-point constants, configuration
// register indexes, the CORDIC arctangent table, and the control structs.
// ============================================================================
`default_nettype none

package tepd_pkg;

    // Default values for the top-level parameters.
    localparam int FILTER_SHIFT_DEF = 6;
    localparam int DERIV_LAG_DEF    = 4;
    localparam int DUTY_MAX_DEF     = 2000;
    localparam int CORDIC_ITERS_DEF = 16;

    // Field widths fixed by the interface.
    localparam int SAMPLE_W    = 32;
    localparam int ANGLE_W     = 32;
    localparam int DUTY_LVL_W  = 11;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 25;
    localparam int TARGET_W    = 25;
    localparam int GAIN_W      = 24;
    localparam int ACCUM_W     = 48;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [GAIN_W-1:0] GAIN_P_RST = 24'd51200;
    localparam logic [GAIN_W-1:0] GAIN_I_RST = 24'd384;
    localparam logic [GAIN_W-1:0] GAIN_D_RST = 24'd4608000;

    // Fixed-point constants (Q15 scale).
    localparam logic signed [24:0] BLEND_KEEP_Q15 = 25'sd32735;
    localparam logic signed [24:0] DT_Q15         = 25'sd328;
    localparam logic signed [31:0] DEG90_Q15      = 32'sd2949120;
    localparam logic signed [25:0] DEG180_Q15     = 26'sd5898240;

    // The CORDIC never runs more steps than the table holds.
    localparam int ATAN_ENTRIES = 24;
    localparam int ATAN_IDX_W   = 5;
    localparam int ATAN_W       = 21;

    // Arctangent of 2^-i in degrees, Q15.
    function automatic logic [ATAN_W-1:0] atan_deg(input logic [ATAN_IDX_W-1:0] idx);
        logic [ATAN_W-1:0] val;
        case (idx)
            5'd0:    val = 21'd1474560;
            5'd1:    val = 21'd870484;
            5'd2:    val = 21'd459940;
            5'd3:    val = 21'd233473;
            5'd4:    val = 21'd117189;
            5'd5:    val = 21'd58653;
            5'd6:    val = 21'd29333;
            5'd7:    val = 21'd14667;
            5'd8:    val = 21'd7334;
            5'd9:    val = 21'd3667;
            5'd10:   val = 21'd1833;
            5'd11:   val = 21'd917;
            5'd12:   val = 21'd458;
            5'd13:   val = 21'd229;
            5'd14:   val = 21'd115;
            5'd15:   val = 21'd57;
            5'd16:   val = 21'd29;
            5'd17:   val = 21'd14;
            5'd18:   val = 21'd7;
            5'd19:   val = 21'd4;
            5'd20:   val = 21'd2;
            5'd21:   val = 21'd1;
            default: val = 21'd0;
        endcase
        return val;
    endfunction

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic filt;
        logic cinit;
        logic citer;
        logic blend1;
        logic blend2;
        logic calc_err;
        logic mul_p;
        logic mul_d;
        logic mul_i;
        logic accum;
        logic div_step;
        logic cap;
        logic mul_lo;
        logic mul_hi;
        logic sum;
        logic out_load;
    } tepd_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic cord_zero;
        logic cord_last;
        logic div_last;
        logic out_free;
    } tepd_stat_t;

endpackage

`default_nettype wire

// File: sv/tepd_ctrl.sv
// ============================================================================
// tepd_ctrl: sequencer for the tilt estimate / PID duty block
// Steps one sample word through filter, CORDIC, blend, PID multiplies,
// integral cap division and output, issuing one command per state.
// ============================================================================
`default_nettype none

module tepd_ctrl (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    output logic                s_ready,
    input  tepd_pkg::tepd_stat_t stat,
    output tepd_pkg::tepd_cmd_t  cmd
);

    typedef enum logic [16:0] {
        ST_IDLE   = 17'd1,
        ST_FILT   = 17'd2,
        ST_CINIT  = 17'd4,
        ST_CITER  = 17'd8,
        ST_BLND1  = 17'd16,
        ST_BLND2  = 17'd32,
        ST_ERR    = 17'd64,
        ST_MULP   = 17'd128,
        ST_MULD   = 17'd256,
        ST_MULI   = 17'd512,
        ST_ACCUM  = 17'd1024,
        ST_DIVIDE = 17'd2048,
        ST_CAP    = 17'd4096,
        ST_MULLO  = 17'd8192,
        ST_MULHI  = 17'd16384,
        ST_SUM    = 17'd32768,
        ST_DONE   = 17'd65536
    } state_t;

    state_t state_reg, state_next;

    // Next-state logic and command decode.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                cmd.load = s_valid;
                if (s_valid) begin
                    state_next = ST_FILT;
                end
            end
            ST_FILT: begin
                cmd.filt   = 1'b1;
                state_next = ST_CINIT;
            end
            ST_CINIT: begin
                cmd.cinit = 1'b1;
                // A zero vector skips the rotation altogether.
                if (stat.cord_zero) begin
                    state_next = ST_BLND1;
                end else begin
                    state_next = ST_CITER;
                end
            end
            ST_CITER: begin
                cmd.citer = 1'b1;
                if (stat.cord_last) begin
                    state_next = ST_BLND1;
                end
            end
            ST_BLND1: begin
                cmd.blend1 = 1'b1;
                state_next = ST_BLND2;
            end
            ST_BLND2: begin
                cmd.blend2 = 1'b1;
                state_next = ST_ERR;
            end
            ST_ERR: begin
                cmd.calc_err = 1'b1;
                state_next   = ST_MULP;
            end
            ST_MULP: begin
                cmd.mul_p  = 1'b1;
                state_next = ST_MULD;
            end
            ST_MULD: begin
                cmd.mul_d  = 1'b1;
                state_next = ST_MULI;
            end
            ST_MULI: begin
                cmd.mul_i  = 1'b1;
                state_next = ST_ACCUM;
            end
            ST_ACCUM: begin
                cmd.accum  = 1'b1;
                state_next = ST_DIVIDE;
            end
            ST_DIVIDE: begin
                cmd.div_step = 1'b1;
                if (stat.div_last) begin
                    state_next = ST_CAP;
                end
            end
            ST_CAP: begin
                cmd.cap    = 1'b1;
                state_next = ST_MULLO;
            end
            ST_MULLO: begin
                cmd.mul_lo = 1'b1;
                state_next = ST_MULHI;
            end
            ST_MULHI: begin
                cmd.mul_hi = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM: begin
                cmd.sum    = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                // Wait here until the output register has room.
                cmd.out_load = stat.out_free;
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_ready = (state_reg == ST_IDLE);

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// File: sv/tepd_datapath.sv
// ============================================================================
// tepd_datapath: arithmetic and state for the tilt estimate / PID duty block
// Holds the configuration, filter, CORDIC, blend, PID and divider registers,
// one shared signed multiplier, and the output register.
// ============================================================================
`default_nettype none

module tepd_datapath #(
    parameter int FILTER_SHIFT = tepd_pkg::FILTER_SHIFT_DEF,
    parameter int DERIV_LAG    = tepd_pkg::DERIV_LAG_DEF,
    parameter int DUTY_MAX     = tepd_pkg::DUTY_MAX_DEF,
    parameter int CORDIC_ITERS = tepd_pkg::CORDIC_ITERS_DEF
) (
    input  wire                         aclk,
    input  wire                         aresetn,
    input  tepd_pkg::tepd_cmd_t         cmd,
    output tepd_pkg::tepd_stat_t        stat,
    input  wire                         cfg_valid,
    input  wire  [1:0]                  cfg_index,
    input  wire  [24:0]                 cfg_data,
    input  wire  signed [31:0]          s_accel_y,
    input  wire  signed [31:0]          s_accel_z,
    input  wire  signed [31:0]          s_gyro_x,
    output logic                        m_valid,
    input  wire                         m_ready,
    output logic [10:0]                 m_duty_level,
    output logic                        m_duty_changed,
    output logic signed [31:0]          m_tilt_angle,
    output logic signed [31:0]          m_angle_error
);

    localparam int CORD_N  = (CORDIC_ITERS > tepd_pkg::ATAN_ENTRIES) ?
                             tepd_pkg::ATAN_ENTRIES : CORDIC_ITERS;
    localparam int DUTY_W  = $clog2(DUTY_MAX + 1);
    localparam int DIV_W   = DUTY_W + 23;
    localparam int DCNT_W  = $clog2(DIV_W);
    localparam logic [DIV_W-1:0]  DIVIDEND = DIV_W'(DUTY_MAX) << 23;
    localparam logic [DUTY_W-1:0] DUTY_TOP = DUTY_W'(DUTY_MAX);
    localparam logic signed [73:0] TERM_LIM = 74'sd1 <<< 60;
    localparam logic signed [48:0] ACC_HI   = (49'sd1 <<< 47) - 49'sd1;
    localparam logic signed [48:0] ACC_LO   = -(49'sd1 <<< 47);

    // Configuration registers.
    logic signed [24:0] target_reg;
    logic [23:0]        gain_p_reg, gain_i_reg, gain_d_reg;

    // Sample capture and architectural state.
    logic signed [31:0] ay_reg, az_reg, gx_reg;
    logic signed [31:0] fy_reg, fz_reg, blended_reg, err_reg;
    logic signed [31:0] hist_reg [DERIV_LAG];
    logic signed [47:0] accum_reg;
    logic [10:0]        last_duty_reg;

    // CORDIC registers.
    logic signed [34:0] cx_reg, cy_reg;
    logic signed [25:0] cz_reg;
    logic [4:0]         ci_reg;

    // Shared multiplier and PID terms.
    logic signed [33:0] mul_a;
    logic signed [24:0] mul_b;
    logic signed [58:0] prod_reg;
    logic signed [56:0] pterm_reg;
    logic signed [57:0] dterm_reg;
    logic [47:0]        lo_reg;

    // Integral cap divider.
    logic [23:0]        rem_reg;
    logic [DIV_W-1:0]   quo_reg;
    logic [DCNT_W-1:0]  dcnt_reg;

    // Result staging.
    logic [DUTY_W-1:0]  duty_reg;
    logic               changed_reg;

    // Combinational helpers.
    logic signed [32:0] fy_diff, fz_diff;
    logic signed [31:0] fy_new, fz_new;
    logic signed [31:0] tilt, tilt_sh, gx_sh;
    logic signed [32:0] err_wide, d_diff;
    logic signed [25:0] step;
    logic signed [48:0] acc_sum;
    logic signed [47:0] acc_sat;
    logic [24:0]        rem_sh;
    logic signed [73:0] i_full;
    logic signed [61:0] iterm;
    logic signed [63:0] pid_sum;
    logic signed [40:0] duty_full;
    logic [DUTY_W-1:0]  duty_new;
    logic signed [34:0] cx_sh, cy_sh;
    logic signed [25:0] atan_val;

    // Filter update, blend, error and PID arithmetic.
    always_comb begin
        fy_diff  = 33'(ay_reg) - 33'(fy_reg);
        fz_diff  = 33'(az_reg) - 33'(fz_reg);
        fy_new   = 32'(33'(fy_reg) + (fy_diff >>> FILTER_SHIFT));
        fz_new   = 32'(33'(fz_reg) + (fz_diff >>> FILTER_SHIFT));
        tilt     = 32'(cz_reg) + tepd_pkg::DEG90_Q15;
        tilt_sh  = tilt >>> 10;
        gx_sh    = gx_reg >>> 10;
        err_wide = 33'(target_reg) - 33'(blended_reg);
        d_diff   = 33'(err_reg) - 33'(hist_reg[DERIV_LAG-1]);
        step     = 26'(prod_reg >>> 15);
        acc_sum  = 49'(accum_reg) + 49'(step);
        if (acc_sum > ACC_HI) begin
            acc_sat = 48'(ACC_HI);
        end else if (acc_sum < ACC_LO) begin
            acc_sat = 48'(ACC_LO);
        end else begin
            acc_sat = 48'(acc_sum);
        end
        rem_sh   = {rem_reg, quo_reg[DIV_W-1]};
        i_full   = (74'(prod_reg) <<< 24) + 74'(signed'({1'b0, lo_reg}));
        if (i_full > TERM_LIM) begin
            iterm = 62'(TERM_LIM);
        end else if (i_full < -TERM_LIM) begin
            iterm = 62'(-TERM_LIM);
        end else begin
            iterm = 62'(i_full);
        end
        pid_sum   = 64'(pterm_reg) + 64'(dterm_reg) + 64'(iterm);
        duty_full = pid_sum[63:23];
        if (target_reg == '0 || duty_full < 0) begin
            duty_new = '0;
        end else if (duty_full > 41'(signed'({1'b0, DUTY_TOP}))) begin
            duty_new = DUTY_TOP;
        end else begin
            duty_new = duty_full[DUTY_W-1:0];
        end
        cx_sh    = cx_reg >>> ci_reg;
        cy_sh    = cy_reg >>> ci_reg;
        atan_val = 26'(signed'({1'b0, tepd_pkg::atan_deg(ci_reg)}));
    end

    // Multiplier operand selection.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (1'b1)
            cmd.blend1: begin
                mul_a = 34'(33'(blended_reg) + 33'(gx_sh));
                mul_b = tepd_pkg::BLEND_KEEP_Q15;
            end
            cmd.mul_p: begin
                mul_a = 34'(err_reg);
                mul_b = 25'(signed'({1'b0, gain_p_reg}));
            end
            cmd.mul_d: begin
                mul_a = 34'(d_diff);
                mul_b = 25'(signed'({1'b0, gain_d_reg}));
            end
            cmd.mul_i: begin
                mul_a = 34'(err_reg);
                mul_b = tepd_pkg::DT_Q15;
            end
            cmd.mul_lo: begin
                mul_a = 34'(signed'({1'b0, accum_reg[23:0]}));
                mul_b = 25'(signed'({1'b0, gain_i_reg}));
            end
            cmd.mul_hi: begin
                // The upper half carries the sign of the integral.
                mul_a = 34'(signed'(accum_reg[47:24]));
                mul_b = 25'(signed'({1'b0, gain_i_reg}));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    // Status back to the controller.
    assign stat.cord_zero = (fy_reg == '0) && (fz_reg == '0);
    assign stat.cord_last = (ci_reg == 5'(CORD_N - 1));
    assign stat.div_last  = (dcnt_reg == DCNT_W'(DIV_W - 1));
    assign stat.out_free  = !m_valid || m_ready;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg <= '0;
            gain_p_reg <= tepd_pkg::GAIN_P_RST;
            gain_i_reg <= tepd_pkg::GAIN_I_RST;
            gain_d_reg <= tepd_pkg::GAIN_D_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                tepd_pkg::CFG_TARGET: target_reg <= cfg_data;
                tepd_pkg::CFG_GAIN_P: gain_p_reg <= cfg_data[23:0];
                tepd_pkg::CFG_GAIN_I: gain_i_reg <= cfg_data[23:0];
                tepd_pkg::CFG_GAIN_D: gain_d_reg <= cfg_data[23:0];
                default: begin
                end
            endcase
        end
    end

    // Sample capture, CORDIC, PID terms and divider: payload only.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            ay_reg <= s_accel_y;
            az_reg <= s_accel_z;
            gx_reg <= s_gyro_x;
        end
        if (cmd.cinit) begin
            ci_reg <= '0;
            // A vector in the left half plane is turned by half a circle first.
            if (stat.cord_zero) begin
                cx_reg <= '0;
                cy_reg <= '0;
                cz_reg <= '0;
            end else if (fz_reg < 0) begin
                cx_reg <= -35'(fz_reg);
                cy_reg <= -35'(fy_reg);
                cz_reg <= (fy_reg >= 0) ? tepd_pkg::DEG180_Q15 : -tepd_pkg::DEG180_Q15;
            end else begin
                cx_reg <= 35'(fz_reg);
                cy_reg <= 35'(fy_reg);
                cz_reg <= '0;
            end
        end
        if (cmd.citer) begin
            ci_reg <= ci_reg + 5'd1;
            if (cy_reg >= 0) begin
                cx_reg <= cx_reg + cy_sh;
                cy_reg <= cy_reg - cx_sh;
                cz_reg <= cz_reg + atan_val;
            end else begin
                cx_reg <= cx_reg - cy_sh;
                cy_reg <= cy_reg + cx_sh;
                cz_reg <= cz_reg - atan_val;
            end
        end
        if (cmd.calc_err) begin
            if (err_wide[32] != err_wide[31]) begin
                err_reg <= err_wide[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
            end else begin
                err_reg <= err_wide[31:0];
            end
        end
        if (cmd.mul_d) begin
            pterm_reg <= prod_reg[56:0];
        end
        if (cmd.mul_i) begin
            dterm_reg <= prod_reg[57:0];
        end
        if (cmd.mul_hi) begin
            lo_reg <= prod_reg[47:0];
        end
        // Restoring division for the integral cap, one quotient bit a cycle.
        if (cmd.accum) begin
            rem_reg  <= '0;
            quo_reg  <= DIVIDEND;
            dcnt_reg <= '0;
        end
        if (cmd.div_step) begin
            dcnt_reg <= dcnt_reg + DCNT_W'(1);
            if (rem_sh >= {1'b0, gain_i_reg}) begin
                rem_reg <= 24'(rem_sh - {1'b0, gain_i_reg});
                quo_reg <= {quo_reg[DIV_W-2:0], 1'b1};
            end else begin
                rem_reg <= rem_sh[23:0];
                quo_reg <= {quo_reg[DIV_W-2:0], 1'b0};
            end
        end
        if (cmd.sum) begin
            duty_reg    <= duty_new;
            changed_reg <= (32'(duty_new) != 32'(last_duty_reg));
        end
        if (cmd.out_load) begin
            m_duty_level   <= 11'(duty_reg);
            m_duty_changed <= changed_reg;
            m_tilt_angle   <= blended_reg;
            m_angle_error  <= err_reg;
        end
    end

    // Architectural state that reset clears.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fy_reg        <= '0;
            fz_reg        <= '0;
            blended_reg   <= '0;
            accum_reg     <= '0;
            last_duty_reg <= '0;
            for (int k = 0; k < DERIV_LAG; k++) begin
                hist_reg[k] <= '0;
            end
        end else begin
            if (cmd.filt) begin
                fy_reg <= fy_new;
                fz_reg <= fz_new;
            end
            if (cmd.blend2) begin
                blended_reg <= prod_reg[46:15] + tilt_sh;
            end
            if (cmd.accum && target_reg != '0) begin
                accum_reg <= acc_sat;
            end
            if (cmd.cap && target_reg != '0 && gain_i_reg != '0 &&
                49'(accum_reg) > 49'(signed'({1'b0, quo_reg}))) begin
                accum_reg <= 48'(signed'({1'b0, quo_reg}));
            end
            if (cmd.sum) begin
                last_duty_reg <= 11'(duty_new);
                hist_reg[0]   <= err_reg;
                for (int k = 1; k < DERIV_LAG; k++) begin
                    hist_reg[k] <= hist_reg[k-1];
                end
            end
        end
    end

    // Output word valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid <= 1'b1;
        end else if (m_ready) begin
            m_valid <= 1'b0;
        end
    end

endmodule

`default_nettype wire

// File: sv/tilt_estimate_pid_duty.sv
// ============================================================================
// tilt_estimate_pid_duty: accelerometer/gyro tilt estimate with PID duty out
// Filters the acceleration, finds the tilt by CORDIC, blends it with the gyro
// rate and runs a PID loop with a capped integral to give a PWM duty level.
// ============================================================================
// A zero vector skips the CORDIC rotation. The block holds one input word at a
// time: it runs the serial CORDIC and the one-bit-per-cycle divider on it and
// takes no new word until its result is loaded into the output register; a held
// result stalls the next word.
// Reset (aresetn, synchronous): filters, angle, history, integral and last
// duty clear to zero; gains return to their defaults and the target to zero.
`default_nettype none

module tilt_estimate_pid_duty #(
    parameter int FILTER_SHIFT = tepd_pkg::FILTER_SHIFT_DEF,
    parameter int DERIV_LAG    = tepd_pkg::DERIV_LAG_DEF,
    parameter int DUTY_MAX     = tepd_pkg::DUTY_MAX_DEF,
    parameter int CORDIC_ITERS = tepd_pkg::CORDIC_ITERS_DEF
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 cfg_valid,
    output logic                cfg_ready,
    input  wire  [1:0]          cfg_index,
    input  wire  [24:0]         cfg_data,
    input  wire                 s_valid,
    output logic                s_ready,
    input  wire  signed [31:0]  s_accel_y,
    input  wire  signed [31:0]  s_accel_z,
    input  wire  signed [31:0]  s_gyro_x,
    output logic                m_valid,
    input  wire                 m_ready,
    output logic [10:0]         m_duty_level,
    output logic                m_duty_changed,
    output logic signed [31:0]  m_tilt_angle,
    output logic signed [31:0]  m_angle_error
);

    tepd_pkg::tepd_cmd_t  cmd;
    tepd_pkg::tepd_stat_t stat;

    // Registers can be written on any cycle.
    assign cfg_ready = 1'b1;

    tepd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    tepd_datapath #(
        .FILTER_SHIFT (FILTER_SHIFT),
        .DERIV_LAG    (DERIV_LAG),
        .DUTY_MAX     (DUTY_MAX),
        .CORDIC_ITERS (CORDIC_ITERS)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .stat           (stat),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_accel_y      (s_accel_y),
        .s_accel_z      (s_accel_z),
        .s_gyro_x       (s_gyro_x),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_duty_level   (m_duty_level),
        .m_duty_changed (m_duty_changed),
        .m_tilt_angle   (m_tilt_angle),
        .m_angle_error  (m_angle_error)
    );

    // The duty level never exceeds its ceiling.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (32'(m_duty_level) <= 32'(DUTY_MAX)))
        else $error("duty level above ceiling");

    // Only one word is in work at a time.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second word accepted while busy");

    // A result never appears in the cycle after a word is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !m_valid |=> !m_valid)
        else $error("result appeared too early");

endmodule

`default_nettype wire

// File: tb/tepd_checker.sv
// ============================================================================
// tepd_checker: result predictor and scoreboard for tilt_estimate_pid_duty
// Watches the configuration, sample and result channels, keeps its own copy
// of the filter, CORDIC and PID state, and compares every result word.
// ============================================================================
`timescale 1ns / 1ps

module tepd_checker (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         cfg_valid,
    input  wire         cfg_ready,
    input  wire  [1:0]  cfg_index,
    input  wire  [24:0] cfg_data,
    input  wire         s_valid,
    input  wire         s_ready,
    input  wire  [31:0] s_accel_y,
    input  wire  [31:0] s_accel_z,
    input  wire  [31:0] s_gyro_x,
    input  wire         m_valid,
    input  wire         m_ready,
    input  wire  [10:0] m_duty_level,
    input  wire         m_duty_changed,
    input  wire  [31:0] m_angle_error,
    input  wire  [31:0] m_tilt_angle,
    output int          fail_count,
    output int          pending
);

    localparam longint TERM_LIM = 64'sd1 << 60;
    localparam longint ACC_HI   = (64'sd1 <<< 47) - 1;
    localparam longint ACC_LO   = -(64'sd1 <<< 47);
    localparam int     LAG      = tepd_pkg::DERIV_LAG_DEF;

    typedef struct {
        logic [10:0] duty;
        logic        changed;
        logic [31:0] tilt;
        logic [31:0] err;
    } duty_word_t;

    duty_word_t duty_expected[$];

    // Mirror of the block's configuration and state.
    longint target, kp, ki, kd;
    longint filt_y, filt_z, tilt_est, integral;
    longint err_hist[LAG];
    logic [10:0] prev_duty;

    // Arithmetic shift right that rounds toward minus infinity.
    function automatic longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint to_s32(longint v);
        logic [31:0] w;
        w = v[31:0];
        return longint'($signed(w));
    endfunction

    function automatic longint q15_mul(longint a, longint b);
        return to_s32(floor_shr(a * b, 15));
    endfunction

    function automatic longint gain_term(longint g, longint b);
        longint mag;
        if (g == 0 || b == 0) return 0;
        mag = (b < 0) ? -b : b;
        if (mag > TERM_LIM / g) return (b < 0) ? -TERM_LIM : TERM_LIM;
        return (b < 0) ? -(g * mag) : g * mag;
    endfunction

    function automatic longint tilt_atan2(longint y, longint x);
        longint z, nx, ny;
        int n;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            z = (y >= 0) ? 5898240 : -5898240;
            x = -x;
            y = -y;
        end
        n = (tepd_pkg::CORDIC_ITERS_DEF > tepd_pkg::ATAN_ENTRIES) ?
            tepd_pkg::ATAN_ENTRIES : tepd_pkg::CORDIC_ITERS_DEF;
        for (int i = 0; i < n; i++) begin
            if (y >= 0) begin
                nx = x + floor_shr(y, i);
                ny = y - floor_shr(x, i);
                z += longint'(tepd_pkg::atan_deg(i[4:0]));
            end else begin
                nx = x - floor_shr(y, i);
                ny = y + floor_shr(x, i);
                z -= longint'(tepd_pkg::atan_deg(i[4:0]));
            end
            x = nx;
            y = ny;
        end
        return z;
    endfunction

    // One control tick: update the state and queue the expected word.
    task automatic predict_duty(logic [31:0] ay, logic [31:0] az, logic [31:0] gx);
        longint acc_tilt, err, pt, it, dt, duty, cap;
        duty_word_t w;
        filt_y += floor_shr(longint'($signed(ay)) - filt_y, tepd_pkg::FILTER_SHIFT_DEF);
        filt_z += floor_shr(longint'($signed(az)) - filt_z, tepd_pkg::FILTER_SHIFT_DEF);
        acc_tilt = tilt_atan2(filt_y, filt_z) + 2949120;
        tilt_est = to_s32(q15_mul(tilt_est + q15_mul(longint'($signed(gx)), 32), 32735)
                          + q15_mul(acc_tilt, 32));
        err = target - tilt_est;
        if (err > 64'sd2147483647) err = 64'sd2147483647;
        else if (err < -64'sd2147483648) err = -64'sd2147483648;
        pt = gain_term(kp, err);
        dt = gain_term(kd, err - err_hist[LAG-1]);
        for (int k = LAG - 1; k > 0; k--) err_hist[k] = err_hist[k-1];
        err_hist[0] = err;
        if (target != 0) begin
            integral += floor_shr(err * 328, 15);
            if (integral > ACC_HI) integral = ACC_HI;
            else if (integral < ACC_LO) integral = ACC_LO;
            if (ki != 0) begin
                cap = (longint'(tepd_pkg::DUTY_MAX_DEF) <<< 23) / ki;
                if (integral > cap) integral = cap;
            end
        end
        it = gain_term(ki, integral);
        duty = floor_shr(pt + it + dt, 23);
        if (target == 0 || duty < 0) duty = 0;
        else if (duty > tepd_pkg::DUTY_MAX_DEF) duty = tepd_pkg::DUTY_MAX_DEF;
        w.duty = duty[10:0];
        w.changed = (duty[10:0] != prev_duty);
        w.tilt = tilt_est[31:0];
        w.err = err[31:0];
        prev_duty = duty[10:0];
        duty_expected.push_back(w);
    endtask

    assign pending = duty_expected.size();

    always @(posedge aclk) begin
        duty_word_t e;
        if (!aresetn) begin
            target = 0;
            kp = tepd_pkg::GAIN_P_RST;
            ki = tepd_pkg::GAIN_I_RST;
            kd = tepd_pkg::GAIN_D_RST;
            filt_y = 0; filt_z = 0; tilt_est = 0; integral = 0; prev_duty = '0;
            for (int k = 0; k < LAG; k++) err_hist[k] = 0;
            duty_expected.delete();
            fail_count = 0;
        end else begin
            // Register writes.
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    tepd_pkg::CFG_TARGET: target = longint'($signed(cfg_data));
                    tepd_pkg::CFG_GAIN_P: kp = longint'(cfg_data[23:0]);
                    tepd_pkg::CFG_GAIN_I: ki = longint'(cfg_data[23:0]);
                    tepd_pkg::CFG_GAIN_D: kd = longint'(cfg_data[23:0]);
                    default: begin
                    end
                endcase
            end
            // Result words are checked before the new sample is predicted.
            if (m_valid && m_ready) begin
                if (duty_expected.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) $display("unexpected result word");
                end else begin
                    e = duty_expected.pop_front();
                    if (e.duty !== m_duty_level || e.changed !== m_duty_changed ||
                        e.tilt !== m_tilt_angle || e.err !== m_angle_error) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("mismatch: exp duty %0d chg %0d tilt %h err %h",
                                     e.duty, e.changed, e.tilt, e.err);
                            $display("          got duty %0d chg %0d tilt %h err %h",
                                     m_duty_level, m_duty_changed,
                                     m_tilt_angle, m_angle_error);
                        end
                    end
                end
            end
            if (s_valid && s_ready) predict_duty(s_accel_y, s_accel_z, s_gyro_x);
        end
    end

endmodule

// File: tb/tb_tilt_estimate_pid_duty.sv
// ============================================================================
// tb_tilt_estimate_pid_duty: testbench top for the tilt / PID duty block
// Drives directed and random IMU samples through several register settings
// with random idling on both sides; the checker judges every result word.
// ============================================================================
`timescale 1ns / 1ps

module tb_tilt_estimate_pid_duty;

    localparam int LIMIT = 400000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = tepd_pkg::CFG_TARGET;
    logic [24:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [31:0] s_accel_y = '0, s_accel_z = '0, s_gyro_x = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [10:0] m_duty_level;
    logic        m_duty_changed;
    logic [31:0] m_tilt_angle, m_angle_error;
    int          fail_count, pending;
    int          cycles = 0;
    bit          calm = 1'b0;

    always #5 aclk = ~aclk;

    tilt_estimate_pid_duty u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_accel_y(s_accel_y), .s_accel_z(s_accel_z), .s_gyro_x(s_gyro_x),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_duty_level(m_duty_level), .m_duty_changed(m_duty_changed),
        .m_tilt_angle(m_tilt_angle), .m_angle_error(m_angle_error)
    );

    tepd_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_accel_y(s_accel_y), .s_accel_z(s_accel_z), .s_gyro_x(s_gyro_x),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_duty_level(m_duty_level), .m_duty_changed(m_duty_changed),
        .m_angle_error(m_angle_error), .m_tilt_angle(m_tilt_angle),
        .fail_count(fail_count), .pending(pending)
    );

    // Watchdog.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Result side stalls in bursts of random length.
    initial begin
        int n;
        forever begin
            @(posedge aclk);
            if (!calm && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 5);
                m_ready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    // Each write drops cfg_valid after acceptance and idles before returning, so the next one starts afresh.
    task automatic write_reg(logic [1:0] idx, logic [24:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_word(logic [31:0] ay, logic [31:0] az, logic [31:0] gx);
        if (!calm && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 5)) @(posedge aclk);
        s_accel_y <= ay;
        s_accel_z <= az;
        s_gyro_x <= gx;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Waits for every result, then lets the block settle before a write.
    task automatic drain;
        while (pending != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    // Mostly gentle, realistic samples; sometimes any 32-bit value.
    function automatic logic [31:0] rand_sample();
        if ($urandom_range(0, 4) == 0) return $urandom;
        return 32'($signed($urandom_range(0, 131072)) - 65536);
    endfunction

    initial begin
        logic [24:0] tgt;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: zero vector, sign quadrants, field extremes, drive off.
        send_word(32'h0, 32'h0, 32'h0);
        send_word(32'h0000_8000, 32'h0000_8000, 32'h0);
        send_word(32'h0000_8000, 32'hFFFF_8000, 32'h0);
        send_word(32'hFFFF_8000, 32'hFFFF_8000, 32'h0);
        send_word(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_word(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_word(32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
        drain();
        write_reg(tepd_pkg::CFG_TARGET, 25'h0FF_FFFF);
        write_reg(tepd_pkg::CFG_GAIN_I, 25'h0FF_FFFF);
        send_word(32'h0, 32'h7FFF_FFFF, 32'h0);
        send_word(32'h8000_0000, 32'h0, 32'h8000_0000);
        send_word(32'h0, 32'h8000_0000, 32'h7FFF_FFFF);
        send_word(32'hAAAA_5555, 32'h5555_AAAA, 32'hA5A5_5A5A);
        drain();
        write_reg(tepd_pkg::CFG_TARGET, 25'h100_0000);
        write_reg(tepd_pkg::CFG_GAIN_P, 25'h0FF_FFFF);
        write_reg(tepd_pkg::CFG_GAIN_D, 25'h0FF_FFFF);
        write_reg(tepd_pkg::CFG_GAIN_I, 25'h0);
        repeat (6) send_word(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);

        // Random phases through several register settings.
        for (int ph = 0; ph < 10; ph++) begin
            drain();
            if (ph == 9) calm = 1'b1;
            case (ph % 4)
                0: tgt = 25'($signed($urandom_range(0, 2 * 2949120)) - 2949120);
                1: tgt = '0;
                2: tgt = 25'($urandom);
                default: tgt = 25'($signed($urandom_range(0, 655360)) - 327680);
            endcase
            write_reg(tepd_pkg::CFG_TARGET, tgt);
            write_reg(tepd_pkg::CFG_GAIN_P,
                      (ph == 3) ? 25'h0 : 25'($urandom_range(0, 200000)));
            write_reg(tepd_pkg::CFG_GAIN_I,
                      (ph == 5) ? 25'h0 : 25'($urandom_range(1, 20000)));
            write_reg(tepd_pkg::CFG_GAIN_D, (ph == 7) ? 25'hFF_FFFF : 25'($urandom));
            repeat (73) send_word(rand_sample(), rand_sample(), rand_sample());
        end

        while (pending != 0 && cycles < LIMIT) @(posedge aclk);
        repeat (80) @(posedge aclk);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
